>>> hdl/nec_ir_pkg.sv
// Shared types and constants for the NEC IR frame decoder.
// No dependencies; imported by every module of the block.
package nec_ir_pkg;

  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAME_BITS = 32;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS);
  localparam int BYTE_W     = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_NOM  = 3'd0,
    REG_REPEAT_NOM = 3'd1,
    REG_HDR_TOL    = 3'd2,
    REG_ZERO_NOM   = 3'd3,
    REG_ONE_NOM    = 3'd4,
    REG_BIT_TOL    = 3'd5
  } cfg_reg_t;

  localparam logic [TICK_W-1:0] START_NOM_RST  = 16'd13500;
  localparam logic [TICK_W-1:0] REPEAT_NOM_RST = 16'd11250;
  localparam logic [TICK_W-1:0] HDR_TOL_RST    = 16'd900;
  localparam logic [TICK_W-1:0] ZERO_NOM_RST   = 16'd1120;
  localparam logic [TICK_W-1:0] ONE_NOM_RST    = 16'd2250;
  localparam logic [TICK_W-1:0] BIT_TOL_RST    = 16'd500;

  // Priorities already resolved: start beats repeat, zero beats one.
  typedef struct packed {
    logic is_start;
    logic is_repeat;
    logic is_zero;
    logic is_one;
  } edge_class_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // [nom - tol, nom + tol], low end saturating at zero, high end unwrapped
  function automatic logic in_window(logic [TICK_W-1:0] t, logic [TICK_W-1:0] nom,
                                     logic [TICK_W-1:0] tol);
    logic [TICK_W:0] lo;
    logic [TICK_W:0] hi;
    lo = (nom > tol) ? {1'b0, nom - tol} : '0;
    hi = {1'b0, nom} + {1'b0, tol};
    return ({1'b0, t} >= lo) && ({1'b0, t} <= hi);
  endfunction

endpackage

>>> hdl/nec_ir_frame_decoder.sv
// Top level of the NEC IR frame decoder: front classifier, edge queue, back decoder.
// Depends on nec_ir_pkg, nec_ir_classify, nec_ir_queue, nec_ir_decode.
//
// One word per falling edge of the IR line, carrying the tick count since the
// previous edge; one result word per input word. A word is taken every cycle
// while the two-entry edge queue has room; its result passes through the queue
// and then the result register. The front end compares each interval against
// the four timing windows in the same cycle it is taken; the back end steps the
// frame state machine once per queued word. The user must write the timing
// registers through the cfg port only while no word is in flight; the block
// does not enforce this. Writes to unused indexes are dropped.
module nec_ir_frame_decoder
  import nec_ir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] interval_ticks
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [7:0] address, [15:8] command
  output logic [1:0]           out_tuser,  // [0] frame_valid, [1] repeat_code
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  edge_class_t cls, q_data;
  logic        q_full, q_valid, q_pop, push;

  assign in_tready = ~q_full;
  assign push      = in_tvalid & in_tready;

  nec_ir_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ticks     (in_tdata),
    .cls       (cls)
  );

  nec_ir_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  nec_ir_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hdl/nec_ir_classify.sv
// Front end: holds the timing registers and classifies each interval word.
// Depends on nec_ir_pkg.
module nec_ir_classify
  import nec_ir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata,
  input  logic [TICK_W-1:0]    ticks,
  output edge_class_t          cls
);

  logic [TICK_W-1:0] start_nom_r, repeat_nom_r, hdr_tol_r;
  logic [TICK_W-1:0] zero_nom_r, one_nom_r, bit_tol_r;
  logic start_hit, repeat_hit, zero_hit, one_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_nom_r  <= START_NOM_RST;
      repeat_nom_r <= REPEAT_NOM_RST;
      hdr_tol_r    <= HDR_TOL_RST;
      zero_nom_r   <= ZERO_NOM_RST;
      one_nom_r    <= ONE_NOM_RST;
      bit_tol_r    <= BIT_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_NOM:  start_nom_r  <= cfg_wdata;
        REG_REPEAT_NOM: repeat_nom_r <= cfg_wdata;
        REG_HDR_TOL:    hdr_tol_r    <= cfg_wdata;
        REG_ZERO_NOM:   zero_nom_r   <= cfg_wdata;
        REG_ONE_NOM:    one_nom_r    <= cfg_wdata;
        REG_BIT_TOL:    bit_tol_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign start_hit  = in_window(ticks, start_nom_r, hdr_tol_r);
  assign repeat_hit = in_window(ticks, repeat_nom_r, hdr_tol_r);
  assign zero_hit   = in_window(ticks, zero_nom_r, bit_tol_r);
  assign one_hit    = in_window(ticks, one_nom_r, bit_tol_r);

  always_comb begin
    cls.is_start  = start_hit;
    cls.is_repeat = repeat_hit & ~start_hit;
    cls.is_zero   = zero_hit;
    cls.is_one    = one_hit & ~zero_hit;
  end

endmodule

>>> hdl/nec_ir_queue.sv
// Short queue of classified edges between front and back ends.
// Depends on nec_ir_pkg.
module nec_ir_queue
  import nec_ir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  edge_class_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output edge_class_t pop_data
);

  edge_class_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hdl/nec_ir_decode.sv
// Back end: frame state machine, bit assembly, complement check, result register.
// Depends on nec_ir_pkg.
module nec_ir_decode
  import nec_ir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  edge_class_t       q_data,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [2*BYTE_W-1:0] out_tdata,
  output logic [1:0]        out_tuser
);

  phase_t                  phase_r, phase_nxt;
  logic [BIT_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FRAME_BITS-1:0]   bits_r, bits_nxt;
  logic [BYTE_W-1:0]       addr_r, addr_nxt, cmd_r, cmd_nxt;
  logic                    out_valid_r, valid_nxt, rep_nxt;
  logic                    frame_r, rep_r;
  logic                    bit_ok, last_bit, check_ok;

  // a new word goes in whenever the result register is free or being drained
  assign q_pop    = q_valid && (!out_valid_r || out_tready);
  assign bit_ok   = q_data.is_zero | q_data.is_one;
  assign last_bit = (cnt_r == BIT_CNT_W'(FRAME_BITS - 1));

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_LEADER: begin
        if (q_data.is_start) begin
          phase_nxt = PH_DATA;
        end else if (q_data.is_repeat) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (!bit_ok) begin
          phase_nxt = PH_LEADER;
        end else if (last_bit) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_LEADER;
    endcase
  end

  always_comb begin
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    valid_nxt = 1'b0;
    rep_nxt   = 1'b0;
    check_ok  = 1'b0;
    unique case (phase_r)
      PH_LEADER: begin
        if (q_data.is_start) begin
          cnt_nxt = '0;
        end else if (q_data.is_repeat) begin
          rep_nxt = 1'b1;
        end
      end
      PH_DATA: begin
        if (bit_ok) begin
          bits_nxt[cnt_r] = q_data.is_one;
          cnt_nxt = cnt_r + 1'b1;
          // byte1 = ~byte0, byte3 = ~byte2
          check_ok = (bits_nxt[15:8] == ~bits_nxt[7:0]) &&
                     (bits_nxt[31:24] == ~bits_nxt[23:16]);
          if (last_bit && check_ok) begin
            addr_nxt  = bits_nxt[7:0];
            cmd_nxt   = bits_nxt[23:16];
            valid_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      bits_r      <= '0;
      addr_r      <= '0;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
      frame_r     <= 1'b0;
      rep_r       <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        bits_r      <= bits_nxt;
        addr_r      <= addr_nxt;
        cmd_r       <= cmd_nxt;
        frame_r     <= valid_nxt;
        rep_r       <= rep_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // held address/command only move on a pop, so they are stable while stalled
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {cmd_r, addr_r};
  assign out_tuser  = {rep_r, frame_r};

endmodule

>>> verif/tb.sv
// Testbench for nec_ir_frame_decoder: directed and random edge streams through
// the stream ports, every result word checked against a decoder model kept here.
// Depends on nec_ir_pkg and the decoder RTL.
module tb;
  import nec_ir_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned MAX_TICKS    = 65535;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic       frame_valid;
    logic       repeat_code;
    logic [7:0] address;
    logic [7:0] command;
  } ir_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;   // [15:0] interval_ticks
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;       // [7:0] address, [15:8] command
  logic [1:0]           out_tuser;       // [0] frame_valid, [1] repeat_code
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_wdata = '0;

  // decoder model: timing registers and frame state
  logic [15:0] t_start, t_repeat, t_hdr_tol, t_zero, t_one, t_bit_tol;
  phase_t      dec_phase;
  logic [5:0]  dec_bits;
  logic [31:0] dec_shift;
  logic [7:0]  dec_addr, dec_cmd;

  ir_result_t  decoded_q[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;

  nec_ir_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: a requested hold-off wins over random stalls
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // distance form of the window; low end saturation falls out of it
  function automatic logic fits(logic [15:0] t, logic [15:0] nom, logic [15:0] tol);
    logic [15:0] gap;
    gap = (t > nom) ? t - nom : nom - t;
    return gap <= tol;
  endfunction

  function automatic ir_result_t decode_edge(logic [15:0] t);
    ir_result_t r;
    logic       bit_ok;
    r = '0;
    bit_ok = 1'b1;
    case (dec_phase)
      PH_LEADER: begin
        if (fits(t, t_start, t_hdr_tol)) begin
          dec_phase = PH_DATA;
          dec_bits  = '0;
        end else if (fits(t, t_repeat, t_hdr_tol)) begin
          r.repeat_code = 1'b1;
          dec_phase     = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (fits(t, t_zero, t_bit_tol)) begin
          dec_shift[dec_bits[4:0]] = 1'b0;
        end else if (fits(t, t_one, t_bit_tol)) begin
          dec_shift[dec_bits[4:0]] = 1'b1;
        end else begin
          bit_ok    = 1'b0;
          dec_bits  = '0;
          dec_phase = PH_LEADER;
        end
        if (bit_ok) begin
          dec_bits = dec_bits + 1'b1;
          if (dec_bits >= FRAME_BITS) begin
            dec_bits = '0;
            if (dec_shift[15:8] == ~dec_shift[7:0] && dec_shift[31:24] == ~dec_shift[23:16]) begin
              dec_addr      = dec_shift[7:0];
              dec_cmd       = dec_shift[23:16];
              r.frame_valid = 1'b1;
            end
            dec_phase = PH_IDLE;
          end
        end
      end
      default: dec_phase = PH_LEADER;
    endcase
    r.address = dec_addr;
    r.command = dec_cmd;
    return r;
  endfunction

  function automatic logic [15:0] jitter_ticks(logic [15:0] nom, logic [15:0] tol);
    int v;
    v = int'(nom) - int'(tol) + int'($urandom_range(2 * int'(tol), 0));
    if (v < 0) v = 0;
    if (v > int'(MAX_TICKS)) v = MAX_TICKS;
    return v[15:0];
  endfunction

  function automatic logic [15:0] window_edge(logic [15:0] nom, logic [15:0] tol, logic upper);
    int v;
    if (upper) v = int'(nom) + int'(tol);
    else v = int'(nom) - int'(tol);
    if (v < 0) v = 0;
    if (v > int'(MAX_TICKS)) v = MAX_TICKS;
    return v[15:0];
  endfunction

  function automatic logic [31:0] nec_word(logic [7:0] addr, logic [7:0] cmd);
    return {~cmd, cmd, ~addr, addr};
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ir_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got tuser %b tdata %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        check_field("frame_valid", 8'(want.frame_valid), 8'(out_tuser[0]));
        check_field("repeat_code", 8'(want.repeat_code), 8'(out_tuser[1]));
        check_field("address", want.address, out_tdata[7:0]);
        check_field("command", want.command, out_tdata[15:8]);
      end
    end
  end

  task automatic send_word(input logic [15:0] ticks);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ticks;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decoded_q.push_back(decode_edge(ticks));
    words_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_START_NOM:  t_start   = val;
      REG_REPEAT_NOM: t_repeat  = val;
      REG_HDR_TOL:    t_hdr_tol = val;
      REG_ZERO_NOM:   t_zero    = val;
      REG_ONE_NOM:    t_one     = val;
      REG_BIT_TOL:    t_bit_tol = val;
      default: ;
    endcase
  endtask

  task automatic apply_timing(input logic [15:0] start_nom, input logic [15:0] repeat_nom,
                              input logic [15:0] hdr_tol, input logic [15:0] zero_nom,
                              input logic [15:0] one_nom, input logic [15:0] bit_tol);
    write_reg(REG_START_NOM, start_nom);
    write_reg(REG_REPEAT_NOM, repeat_nom);
    write_reg(REG_HDR_TOL, hdr_tol);
    write_reg(REG_ZERO_NOM, zero_nom);
    write_reg(REG_ONE_NOM, one_nom);
    write_reg(REG_BIT_TOL, bit_tol);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // arms first if idle; at_edges puts every interval on a window boundary
  task automatic send_frame(input logic [31:0] word, input logic at_edges);
    logic [15:0] nom;
    if (dec_phase == PH_IDLE) send_word(16'($urandom));
    send_word(at_edges ? window_edge(t_start, t_hdr_tol, word[0])
                       : jitter_ticks(t_start, t_hdr_tol));
    for (int i = 0; i < FRAME_BITS; i++) begin
      nom = word[i] ? t_one : t_zero;
      send_word(at_edges ? window_edge(nom, t_bit_tol, i[0]) : jitter_ticks(nom, t_bit_tol));
    end
  endtask

  task automatic test_leader_cases();
    send_word(16'hFFFF);                                      // arm, value ignored
    send_word(window_edge(t_repeat, t_hdr_tol, 1'b0) - 1'b1); // below repeat window
    send_word(window_edge(t_start, t_hdr_tol, 1'b1) + 1'b1);  // above start window
    send_word(window_edge(t_repeat, t_hdr_tol, 1'b0));        // repeat, back to idle
    send_word(16'h0000);
    send_word(window_edge(t_start, t_hdr_tol, 1'b0));
    send_word(window_edge(t_zero, t_bit_tol, 1'b1) + 1'b1);   // gap between bit windows
    send_word(window_edge(t_start, t_hdr_tol, 1'b1));
    send_word(16'h0000);                                      // bad bit drops to leader
    send_word(window_edge(t_repeat, t_hdr_tol, 1'b1));
    wait_drained();
  endtask

  task automatic test_frame_checks();
    send_frame(nec_word(8'h00, 8'hFF), 1'b1);
    send_frame(nec_word(8'hA5, 8'h3C) ^ 32'h0000_0100, 1'b0);  // byte1 not complement
    send_frame(nec_word(8'h5A, 8'hC3) ^ 32'h8000_0000, 1'b0);  // byte3 not complement
    send_frame(nec_word(8'hFF, 8'h00), 1'b1);
    send_word(16'h1234);
    send_word(jitter_ticks(t_repeat, t_hdr_tol));
    wait_drained();
  endtask

  task automatic test_window_extremes();
    write_reg(REG_UNUSED, 16'hFFFF);
    apply_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);
    send_word(16'h0000);
    repeat (5) send_word(16'h0000);
    send_word(16'h0001);
    wait_drained();
    // every interval lands in the start and zero windows
    apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h8000);
    send_word(16'h0000);
    repeat (FRAME_BITS) send_word(16'($urandom));
    wait_drained();
    // overlapping leader and bit windows, zero window clamped at 0
    apply_timing(16'd13500, 16'd13000, 16'd900, 16'd100, 16'd500, 16'd300);
    send_word(16'h0000);
    send_word(16'd13200);
    send_word(16'h0000);
    send_word(16'd300);
    send_word(16'd800);
    send_word(16'd801);
    send_frame(nec_word(8'($urandom), 8'($urandom)), 1'b0);
    wait_drained();
    apply_timing(START_NOM_RST, REPEAT_NOM_RST, HDR_TOL_RST, ZERO_NOM_RST, ONE_NOM_RST,
                 BIT_TOL_RST);
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    hold_len     <= 150;
    hold_seq     <= hold_seq + 1;
    send_frame(nec_word(8'($urandom), 8'($urandom)), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic new_timing);
    int unsigned target;
    int unsigned pick;
    int          start_nom;
    int          zero_nom;
    if (new_timing) begin
      start_nom = $urandom_range(MAX_TICKS, 6000);
      zero_nom  = $urandom_range(3000, 40);
      apply_timing(16'(start_nom), 16'(start_nom * 5 / 6), 16'($urandom_range(start_nom / 8, 0)),
                   16'(zero_nom), 16'(zero_nom * 2), 16'($urandom_range(zero_nom, 0)));
    end
    tx_idle_pct  = tx_pct;
    rx_stall_pct <= rx_pct;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        send_frame(nec_word(8'($urandom), 8'($urandom)), 1'b0);
      end else if (pick < 65) begin
        send_frame($urandom, 1'($urandom_range(1, 0)));
      end else if (pick < 75) begin
        if (dec_phase == PH_IDLE) send_word(16'($urandom));
        send_word(jitter_ticks(t_repeat, t_hdr_tol));
      end else if (pick < 85) begin
        // frame cut short by a noise word
        if (dec_phase == PH_IDLE) send_word(16'($urandom));
        send_word(jitter_ticks(t_start, t_hdr_tol));
        repeat ($urandom_range(31, 1))
          send_word(jitter_ticks($urandom_range(1, 0) ? t_one : t_zero, t_bit_tol));
        send_word(16'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) send_word(16'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    t_start   = START_NOM_RST;
    t_repeat  = REPEAT_NOM_RST;
    t_hdr_tol = HDR_TOL_RST;
    t_zero    = ZERO_NOM_RST;
    t_one     = ONE_NOM_RST;
    t_bit_tol = BIT_TOL_RST;
    dec_phase = PH_IDLE;
    dec_bits  = '0;
    dec_shift = '0;
    dec_addr  = '0;
    dec_cmd   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_leader_cases();
    test_frame_checks();
    test_window_extremes();
    test_backpressure();
    test_random_traffic(0, 0, 1'b0);
    test_random_traffic(56, 0, 1'b1);
    test_random_traffic(0, 56, 1'b1);
    test_random_traffic(19, 19, 1'b1);
    errors += decoded_q.size();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> nec_ir_frame_decoder.f
hdl/nec_ir_pkg.sv
hdl/nec_ir_classify.sv
hdl/nec_ir_queue.sv
hdl/nec_ir_decode.sv
hdl/nec_ir_frame_decoder.sv
verif/tb.sv
